>>> rtl/core/clamped_linear_range_map_macros.svh
// Assertion macros for the clamped linear range map checker.
`ifndef CLAMPED_LINEAR_RANGE_MAP_MACROS_SVH
`define CLAMPED_LINEAR_RANGE_MAP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CLRM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CLRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/clrm_pkg.sv
// Shared types and register indexes of the clamped linear range map.
package clrm_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_IN_LOW     = 3'd0;
   localparam csr_index_type CSR_IN_HIGH    = 3'd1;
   localparam csr_index_type CSR_OUT_LOW    = 3'd2;
   localparam csr_index_type CSR_OUT_HIGH   = 3'd3;
   localparam csr_index_type CSR_PLAIN_MODE = 3'd4;

   // Control flags that ride along with each item down the pipeline.
   typedef struct packed {
      logic bypass;  // result is the carried base value, no scaling
      logic neg;     // scale factor is negative
   } side_type;

endpackage

>>> rtl/core/clrm_stream_ifs.sv
// Valid/ready stream interfaces for the sample and mapped-value channels.
interface clrm_req_if #(parameter int VALUE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface clrm_rsp_if #(parameter int VALUE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] mapped;

   modport source (output valid, output mapped, input ready);
   modport sink   (input valid, input mapped, output ready);
endinterface

>>> rtl/core/clamped_linear_range_map.sv
// Top level of the clamped linear range map.
//
// Each sample item on req_chan gives exactly one mapped item on rsp_chan,
// in order. Both channels move an item on a clock edge where valid and
// ready are high. Configuration is written through csr_we, csr_index and
// csr_wdata while no item is in flight; unknown indexes are ignored.
//
// Each item passes through registered stages in order: the range tests,
// the product, one restoring division cell per quotient bit
// (VALUE_WIDTH + 1 cells) and the output register. Throughput is one
// item per cycle while rsp_chan takes items; every stage is a registered
// cell that hands its item on each cycle unless the next one is stalled.
//
// When the receiver stalls, the result holds in the output register and
// items upstream close up into empty stages, so req_chan stays ready
// until every stage is full. Reset clears every stage and restores the
// register values: source and target ranges 0 to 255, widening mode.
module clamped_linear_range_map #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   clrm_req_if.sink                             req_chan,
   clrm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [clrm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [VALUE_WIDTH-1:0]               csr_wdata
);

   localparam int W = VALUE_WIDTH;
   localparam int NCELL = W + 1;

   // Configuration registers.
   logic signed [W-1:0] in_low_ff, in_low_in;
   logic signed [W-1:0] in_high_ff, in_high_in;
   logic signed [W-1:0] out_low_ff, out_low_in;
   logic signed [W-1:0] out_high_ff, out_high_in;
   logic                plain_mode_ff, plain_mode_in;

   always_comb begin
      in_low_in     = in_low_ff;
      in_high_in    = in_high_ff;
      out_low_in    = out_low_ff;
      out_high_in   = out_high_ff;
      plain_mode_in = plain_mode_ff;
      if (csr_we) begin
         case (csr_index)
            clrm_pkg::CSR_IN_LOW:     in_low_in     = csr_wdata;
            clrm_pkg::CSR_IN_HIGH:    in_high_in    = csr_wdata;
            clrm_pkg::CSR_OUT_LOW:    out_low_in    = csr_wdata;
            clrm_pkg::CSR_OUT_HIGH:   out_high_in   = csr_wdata;
            clrm_pkg::CSR_PLAIN_MODE: plain_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_low_ff     <= '0;
         in_high_ff    <= W'(255);
         out_low_ff    <= '0;
         out_high_ff   <= W'(255);
         plain_mode_ff <= 1'b0;
      end else begin
         in_low_ff     <= in_low_in;
         in_high_ff    <= in_high_in;
         out_low_ff    <= out_low_in;
         out_high_ff   <= out_high_in;
         plain_mode_ff <= plain_mode_in;
      end
   end

   // Front stage to product stage.
   logic               fr_valid, fr_ready;
   logic [W-1:0]       fr_offset;
   logic [W:0]         fr_mag;
   logic [W:0]         fr_den;
   clrm_pkg::side_type fr_side;
   logic [W-1:0]       fr_base;

   clrm_front #(.VALUE_WIDTH(W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .sample     (req_chan.sample),
      .in_low     (in_low_ff),
      .in_high    (in_high_ff),
      .out_low    (out_low_ff),
      .out_high   (out_high_ff),
      .plain_mode (plain_mode_ff),
      .out_valid  (fr_valid),
      .out_ready  (fr_ready),
      .offset     (fr_offset),
      .mag        (fr_mag),
      .den        (fr_den),
      .side       (fr_side),
      .base       (fr_base)
   );

   // Chain links: entry k feeds division cell k, entry NCELL feeds the
   // output stage.
   logic               ch_valid [0:NCELL];
   logic               ch_ready [0:NCELL];
   logic [W:0]         ch_rem   [0:NCELL];
   logic [W:0]         ch_lq    [0:NCELL];
   logic [W:0]         ch_den   [0:NCELL];
   clrm_pkg::side_type ch_side  [0:NCELL];
   logic [W-1:0]       ch_base  [0:NCELL];
   logic [2*W:0]       mu_prod;

   clrm_mult #(.VALUE_WIDTH(W)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .offset    (fr_offset),
      .mag       (fr_mag),
      .den_i     (fr_den),
      .side_i    (fr_side),
      .base_i    (fr_base),
      .out_valid (ch_valid[0]),
      .out_ready (ch_ready[0]),
      .prod      (mu_prod),
      .den_o     (ch_den[0]),
      .side_o    (ch_side[0]),
      .base_o    (ch_base[0])
   );

   // The quotient fits in W + 1 bits, so the upper product bits start out
   // below the divisor and serve as the first partial remainder.
   assign ch_rem[0] = {1'b0, mu_prod[2*W:W+1]};
   assign ch_lq[0]  = mu_prod[W:0];

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      clrm_div_cell #(.VALUE_WIDTH(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[k]),
         .in_ready  (ch_ready[k]),
         .rem_i     (ch_rem[k]),
         .lq_i      (ch_lq[k]),
         .den_i     (ch_den[k]),
         .side_i    (ch_side[k]),
         .base_i    (ch_base[k]),
         .out_valid (ch_valid[k+1]),
         .out_ready (ch_ready[k+1]),
         .rem_o     (ch_rem[k+1]),
         .lq_o      (ch_lq[k+1]),
         .den_o     (ch_den[k+1]),
         .side_o    (ch_side[k+1]),
         .base_o    (ch_base[k+1])
      );
   end

   clrm_back #(.VALUE_WIDTH(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ch_valid[NCELL]),
      .in_ready  (ch_ready[NCELL]),
      .quot      (ch_lq[NCELL]),
      .side      (ch_side[NCELL]),
      .base      (ch_base[NCELL]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .mapped    (rsp_chan.mapped)
   );

endmodule

>>> rtl/core/clrm_front.sv
// Front stage: range tests, span selection and operand preparation.
module clrm_front #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [VALUE_WIDTH-1:0] sample,
   input  logic signed [VALUE_WIDTH-1:0] in_low,
   input  logic signed [VALUE_WIDTH-1:0] in_high,
   input  logic signed [VALUE_WIDTH-1:0] out_low,
   input  logic signed [VALUE_WIDTH-1:0] out_high,
   input  logic                          plain_mode,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [VALUE_WIDTH-1:0]        offset,
   output logic [VALUE_WIDTH:0]          mag,
   output logic [VALUE_WIDTH:0]          den,
   output clrm_pkg::side_type            side,
   output logic [VALUE_WIDTH-1:0]        base
);

   localparam int W = VALUE_WIDTH;

   logic signed [W:0]   in_span;
   logic signed [W:0]   out_span;
   logic signed [W+1:0] num;
   logic [W+1:0]        mag_full;
   logic [W:0]          den_calc;
   logic [W-1:0]        offset_calc;
   logic                widen;
   logic                below;
   logic                above;
   logic                zero_span;

   logic                valid_ff, valid_in;
   logic [W-1:0]        offset_ff, offset_in;
   logic [W:0]          mag_ff, mag_in;
   logic [W:0]          den_ff, den_in;
   clrm_pkg::side_type  side_ff, side_in;
   logic [W-1:0]        base_ff, base_in;

   // Spans at one extra bit so that no difference wraps.
   assign in_span  = {in_high[W-1], in_high} - {in_low[W-1], in_low};
   assign out_span = {out_high[W-1], out_high} - {out_low[W-1], out_low};
   assign widen    = !plain_mode && (in_span > out_span);

   // Numerator and divisor of the scale factor, widened by one when the
   // source span is the larger one and plain mode is off.
   assign num = widen ? ({out_span[W], out_span} + {{(W+1){1'b0}}, 1'b1})
                      : {out_span[W], out_span};
   assign mag_full = num[W+1] ? (~num + {{(W+1){1'b0}}, 1'b1}) : num;
   assign den_calc = widen ? (in_span[W:0] + {{W{1'b0}}, 1'b1}) : in_span[W:0];

   // Clamping tests; the below-minimum test wins on an inverted range.
   assign below       = sample < in_low;
   assign above       = sample > in_high;
   assign zero_span   = !widen && (in_span == '0);
   assign offset_calc = sample - in_low;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      offset_in = offset_ff;
      mag_in    = mag_ff;
      den_in    = den_ff;
      side_in   = side_ff;
      base_in   = base_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         offset_in      = offset_calc;
         mag_in         = mag_full[W:0];
         den_in         = den_calc;
         side_in.bypass = below || above || zero_span;
         side_in.neg    = num[W+1];
         base_in        = (above && !below) ? out_high : out_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      offset_ff <= offset_in;
      mag_ff    <= mag_in;
      den_ff    <= den_in;
      side_ff   <= side_in;
      base_ff   <= base_in;
   end

   assign out_valid = valid_ff;
   assign offset    = offset_ff;
   assign mag       = mag_ff;
   assign den       = den_ff;
   assign side      = side_ff;
   assign base      = base_ff;

endmodule

>>> rtl/core/clrm_mult.sv
// Product stage: offset times scale magnitude at full width.
module clrm_mult #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [VALUE_WIDTH-1:0]   offset,
   input  logic [VALUE_WIDTH:0]     mag,
   input  logic [VALUE_WIDTH:0]     den_i,
   input  clrm_pkg::side_type       side_i,
   input  logic [VALUE_WIDTH-1:0]   base_i,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [2*VALUE_WIDTH:0]   prod,
   output logic [VALUE_WIDTH:0]     den_o,
   output clrm_pkg::side_type       side_o,
   output logic [VALUE_WIDTH-1:0]   base_o
);

   localparam int W = VALUE_WIDTH;
   localparam int PW = 2 * W + 1;

   logic               valid_ff, valid_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [W:0]         den_ff, den_in;
   clrm_pkg::side_type side_ff, side_in;
   logic [W-1:0]       base_ff, base_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      prod_in  = prod_ff;
      den_in   = den_ff;
      side_in  = side_ff;
      base_in  = base_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         prod_in = PW'(offset) * PW'(mag);
         den_in  = den_i;
         side_in = side_i;
         base_in = base_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prod_ff <= prod_in;
      den_ff  <= den_in;
      side_ff <= side_in;
      base_ff <= base_in;
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;
   assign den_o     = den_ff;
   assign side_o    = side_ff;
   assign base_o    = base_ff;

endmodule

>>> rtl/core/clrm_div_cell.sv
// One restoring-division cell: settles one quotient bit per item.
module clrm_div_cell #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [VALUE_WIDTH:0]   rem_i,
   input  logic [VALUE_WIDTH:0]   lq_i,
   input  logic [VALUE_WIDTH:0]   den_i,
   input  clrm_pkg::side_type     side_i,
   input  logic [VALUE_WIDTH-1:0] base_i,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [VALUE_WIDTH:0]   rem_o,
   output logic [VALUE_WIDTH:0]   lq_o,
   output logic [VALUE_WIDTH:0]   den_o,
   output clrm_pkg::side_type     side_o,
   output logic [VALUE_WIDTH-1:0] base_o
);

   localparam int W = VALUE_WIDTH;

   logic [W+1:0]       trial;
   logic [W+1:0]       diff;
   logic               fits;

   logic               valid_ff, valid_in;
   logic [W:0]         rem_ff, rem_in;
   logic [W:0]         lq_ff, lq_in;
   logic [W:0]         den_ff, den_in;
   clrm_pkg::side_type side_ff, side_in;
   logic [W-1:0]       base_ff, base_in;

   // Bring down the next dividend bit and try one subtraction. The low
   // word shifts the dividend bits out at the top and the quotient in.
   assign trial = {rem_i, lq_i[W]};
   assign diff  = trial - {1'b0, den_i};
   assign fits  = trial >= {1'b0, den_i};

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      rem_in   = rem_ff;
      lq_in    = lq_ff;
      den_in   = den_ff;
      side_in  = side_ff;
      base_in  = base_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         rem_in  = fits ? diff[W:0] : trial[W:0];
         lq_in   = {lq_i[W-1:0], fits};
         den_in  = den_i;
         side_in = side_i;
         base_in = base_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff  <= rem_in;
      lq_ff   <= lq_in;
      den_ff  <= den_in;
      side_ff <= side_in;
      base_ff <= base_in;
   end

   assign out_valid = valid_ff;
   assign rem_o     = rem_ff;
   assign lq_o      = lq_ff;
   assign den_o     = den_ff;
   assign side_o    = side_ff;
   assign base_o    = base_ff;

endmodule

>>> rtl/core/clrm_back.sv
// Output stage: applies the sign and adds the base, or passes the base alone for a bypassed item, and holds the result.
module clrm_back #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [VALUE_WIDTH:0]          quot,
   input  clrm_pkg::side_type            side,
   input  logic [VALUE_WIDTH-1:0]        base,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [VALUE_WIDTH-1:0] mapped
);

   localparam int W = VALUE_WIDTH;

   logic [W:0]   quot_signed;
   logic [W-1:0] scaled;

   logic         valid_ff, valid_in;
   logic [W-1:0] mapped_ff, mapped_in;

   // The quotient is a magnitude; negate it for a falling target range.
   assign quot_signed = side.neg ? (~quot + {{W{1'b0}}, 1'b1}) : quot;
   assign scaled      = quot_signed[W-1:0] + base;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      mapped_in = mapped_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         mapped_in = side.bypass ? base : scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mapped_ff <= mapped_in;
   end

   assign out_valid = valid_ff;
   assign mapped    = mapped_ff;

endmodule

>>> rtl/core/clrm_checker.sv
// Port-level checker for the clamped linear range map, with its bind.
`include "clamped_linear_range_map_macros.svh"

module clrm_checker #(
   parameter int VALUE_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_mapped
);

   // A stalled result keeps its value until it is taken.
   `CLRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mapped), "mapped item changed while stalled")

   // Reset empties the whole pipeline.
   `CLRM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")

   // With the output register empty, every stage can move, so input is taken.
   `CLRM_ASSERT_SAME(a_empty_ready, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")

   // A receiver that takes items never back-pressures the input.
   `CLRM_ASSERT_SAME(a_flow_ready, clock, reset, rsp_ready, req_ready, "input stalled while output drains")

endmodule

bind clamped_linear_range_map clrm_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_clrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_mapped (rsp_chan.mapped)
);
